@@ sv/wvrj_pkg.sv @@
// Shared types, codes and saturation helpers for the warped vertex residual block.
`default_nettype none
package wvrj_pkg;
  localparam logic [2:0] OP_GROW = 3'd0;
  localparam logic [2:0] OP_PREV = 3'd1;
  localparam logic [2:0] OP_TGT  = 3'd2;
  localparam logic [2:0] OP_HDR  = 3'd3;
  localparam logic [2:0] OP_NROW = 3'd4;

  localparam logic CFG_COST_WEIGHT = 1'b0;
  localparam logic CFG_JAC_EN      = 1'b1;

  localparam logic KIND_RES = 1'b0;
  localparam logic KIND_JAC = 1'b1;

  localparam logic [1:0] GRP_TRANS = 2'd3;

  typedef logic signed [31:0] q_t;
  typedef q_t vec3_t [3];

  typedef struct packed {
    q_t w;
    q_t z;
    q_t y;
    q_t x;
  } node_t;

  function automatic q_t sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -36'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic q_t sat_sub(input q_t a, input q_t b);
    logic signed [35:0] d;
    d = 36'(a) - 36'(b);
    return sat32(d);
  endfunction
endpackage
`default_nettype wire

@@ sv/wvrj_if.sv @@
// Handshake channels for input items and result words.
`default_nettype none
interface wvrj_in_if;
  logic                valid;
  logic                ready;
  logic [2:0]          opcode;
  logic [1:0]          row;
  logic signed [31:0]  val_a;
  logic signed [31:0]  val_b;
  logic signed [31:0]  val_c;
  logic signed [31:0]  val_d;
  logic                last_node;
  modport source (output valid, opcode, row, val_a, val_b, val_c, val_d, last_node,
                  input ready);
  modport sink (input valid, opcode, row, val_a, val_b, val_c, val_d, last_node,
                output ready);
endinterface

interface wvrj_out_if;
  logic                valid;
  logic                ready;
  logic                kind;
  logic [1:0]          node_index;
  logic [1:0]          residual_row;
  logic [1:0]          group;
  logic signed [31:0]  out_x;
  logic signed [31:0]  out_y;
  logic signed [31:0]  out_z;
  logic                node_overflow;
  logic                last;
  modport source (output valid, kind, node_index, residual_row, group, out_x, out_y,
                  out_z, node_overflow, last, input ready);
  modport sink (input valid, kind, node_index, residual_row, group, out_x, out_y,
                out_z, node_overflow, last, output ready);
endinterface
`default_nettype wire

@@ sv/wvrj_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module wvrj_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AW-1:0]         waddr,
  input  wire logic [WIDTH-1:0]      wdata,
  input  wire logic [AW-1:0]         raddr,
  output logic      [WIDTH-1:0]      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

@@ sv/wvrj_lane.sv @@
// One multiply lane: Q-format product, round half up, saturate, registered.
`default_nettype none
module wvrj_lane #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic signed [32:0] op_a,
  input  wire logic signed [31:0] op_b,
  output logic signed [31:0]      q
);
  localparam logic signed [64:0] RND = 65'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [64:0] QMAX = 65'sd2147483647;
  localparam logic signed [64:0] QMIN = -65'sd2147483648;

  logic signed [64:0] prod;
  logic signed [64:0] shifted;
  logic signed [31:0] q_nxt;
  logic signed [31:0] q_r;

  always_comb begin
    prod = 65'(op_a) * 65'(op_b) + RND;
    shifted = prod >>> FRAC_BITS;
    if (shifted > QMAX) begin
      q_nxt = 32'sh7fffffff;
    end else if (shifted < QMIN) begin
      q_nxt = 32'sh80000000;
    end else begin
      q_nxt = shifted[31:0];
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;
endmodule
`default_nettype wire

@@ sv/wvrj_merge.sv @@
// Merge of lane products with two base terms into one saturated sum.
`default_nettype none
module wvrj_merge (
  input  wire wvrj_pkg::q_t base,
  input  wire wvrj_pkg::q_t offs,
  input  wire wvrj_pkg::q_t p0,
  input  wire wvrj_pkg::q_t p1,
  input  wire wvrj_pkg::q_t p2,
  output wvrj_pkg::q_t      sum
);
  logic signed [35:0] acc;

  always_comb begin
    acc = 36'(base) + 36'(offs) + 36'(p0) + 36'(p1) + 36'(p2);
    sum = wvrj_pkg::sat32(acc);
  end
endmodule
`default_nettype wire

@@ sv/warped_vertex_residual_jacobian.sv @@
// Top level: item decode, node store, three multiply lanes and the result sequencer.
// Loads are taken in the idle state; a node row passes states NA, ND, NP, NS, NM, NW.
// The final row then runs RP, RS, RM, RW per residual row and emits the residual in
// REMIT, then JA to JT per node; the emit states wait while the output is stalled.
// Throughput: one item at a time; the three lanes and one merge set the pace.
// Reset: synchronous, active low; clears the state, config, vertex and transform registers.
`default_nettype none
module warped_vertex_residual_jacobian #(
  parameter int MAX_NODES = 4,
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [30:0] cfg_data,
  wvrj_in_if.sink          in_if,
  wvrj_out_if.source       out_if
);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int JW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_NA    = 5'd1;
  localparam logic [4:0] ST_ND    = 5'd2;
  localparam logic [4:0] ST_NP    = 5'd3;
  localparam logic [4:0] ST_NS    = 5'd4;
  localparam logic [4:0] ST_NM    = 5'd5;
  localparam logic [4:0] ST_NW    = 5'd6;
  localparam logic [4:0] ST_RP    = 5'd7;
  localparam logic [4:0] ST_RS    = 5'd8;
  localparam logic [4:0] ST_RM    = 5'd9;
  localparam logic [4:0] ST_RW    = 5'd10;
  localparam logic [4:0] ST_REMIT = 5'd11;
  localparam logic [4:0] ST_JA    = 5'd12;
  localparam logic [4:0] ST_JC    = 5'd13;
  localparam logic [4:0] ST_JK    = 5'd14;
  localparam logic [4:0] ST_JG    = 5'd15;
  localparam logic [4:0] ST_JH    = 5'd16;
  localparam logic [4:0] ST_JM    = 5'd17;
  localparam logic [4:0] ST_JE    = 5'd18;
  localparam logic [4:0] ST_JT    = 5'd19;

  logic [4:0]           st_r;
  logic [30:0]          cw_r;
  logic                 jen_r;
  wvrj_pkg::q_t         grot_r [3][3];
  wvrj_pkg::q_t         gtr_r  [3];
  wvrj_pkg::q_t         prev_r [3];
  wvrj_pkg::q_t         tgt_r  [3];
  wvrj_pkg::q_t         acc_r  [3];
  logic [CW-1:0]        node_count_r;
  logic                 ovf_r;
  logic                 cur_stored_r;
  logic [JW-1:0]        cur_slot_r;
  logic [1:0]           row_r;
  logic                 lastn_r;
  wvrj_pkg::q_t         va_r [3];
  wvrj_pkg::q_t         vd_r;
  wvrj_pkg::q_t         d_r  [3];
  wvrj_pkg::q_t         s_r;
  wvrj_pkg::q_t         diff_r;
  wvrj_pkg::q_t         res_r [3];
  wvrj_pkg::q_t         coeff_r;
  wvrj_pkg::q_t         cg_r [3];
  logic [1:0]           r_r;
  logic [1:0]           g_r;
  logic [JW-1:0]        j_r;

  logic                 out_valid_r;
  logic                 out_kind_r;
  logic [1:0]           out_node_r;
  logic [1:0]           out_rrow_r;
  logic [1:0]           out_group_r;
  wvrj_pkg::q_t         out_x_r;
  wvrj_pkg::q_t         out_y_r;
  wvrj_pkg::q_t         out_z_r;
  logic                 out_ovf_r;
  logic                 out_last_r;

  logic                 in_fire;
  logic                 emit_ok;
  logic                 emit_fire;
  logic                 hdr_store;
  logic [JW-1:0]        rd_addr;
  wvrj_pkg::node_t      rd_node;
  wvrj_pkg::node_t      wr_node;
  wvrj_pkg::q_t         pos_rd [3];
  wvrj_pkg::q_t         pos_row;
  logic signed [32:0]   lane_a [3];
  wvrj_pkg::q_t         lane_b [3];
  wvrj_pkg::q_t         lane_q [3];
  wvrj_pkg::q_t         mrg_base;
  wvrj_pkg::q_t         mrg_offs;
  wvrj_pkg::q_t         mrg_sum;
  logic                 jac_phase;
  logic                 jac_last;

  assign in_if.ready = (st_r == ST_IDLE);
  assign in_fire = in_if.valid && in_if.ready;
  assign emit_ok = !out_valid_r || out_if.ready;
  assign emit_fire = emit_ok &&
                     ((st_r == ST_REMIT) || (st_r == ST_JE) || (st_r == ST_JT));
  assign hdr_store = in_fire && (in_if.opcode == wvrj_pkg::OP_HDR) &&
                     (node_count_r < CW'(MAX_NODES));
  assign jac_phase = (st_r == ST_JA) || (st_r == ST_JC);
  assign rd_addr = jac_phase ? j_r : cur_slot_r;
  assign jac_last = (r_r == 2'd2) && (CW'(j_r) == node_count_r - CW'(1));

  always_comb begin
    wr_node.x = in_if.val_a;
    wr_node.y = in_if.val_b;
    wr_node.z = in_if.val_c;
    wr_node.w = in_if.val_d;
  end

  wvrj_ram #(
    .WIDTH ($bits(wvrj_pkg::node_t)),
    .DEPTH (MAX_NODES)
  ) u_nodes (
    .clk   (clk),
    .we    (hdr_store),
    .waddr (node_count_r[JW-1:0]),
    .wdata (wr_node),
    .raddr (rd_addr),
    .rdata (rd_node)
  );

  always_comb begin
    pos_rd[0] = rd_node.x;
    pos_rd[1] = rd_node.y;
    pos_rd[2] = rd_node.z;
    case (row_r)
      2'd0:    pos_row = rd_node.x;
      2'd1:    pos_row = rd_node.y;
      default: pos_row = rd_node.z;
    endcase
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      lane_a[c] = '0;
      lane_b[c] = '0;
    end
    case (st_r)
      ST_NP: begin
        for (int c = 0; c < 3; c++) begin
          lane_a[c] = 33'(va_r[c]);
          lane_b[c] = d_r[c];
        end
      end
      ST_NM: begin
        lane_a[0] = 33'(rd_node.w);
        lane_b[0] = s_r;
      end
      ST_RP: begin
        for (int c = 0; c < 3; c++) begin
          lane_a[c] = 33'(grot_r[r_r][c]);
          lane_b[c] = acc_r[c];
        end
      end
      ST_RM: begin
        lane_a[0] = {2'b00, cw_r};
        lane_b[0] = diff_r;
      end
      ST_JC: begin
        lane_a[0] = {2'b00, cw_r};
        lane_b[0] = rd_node.w;
      end
      ST_JG: begin
        for (int c = 0; c < 3; c++) begin
          lane_a[c] = 33'(coeff_r);
          lane_b[c] = grot_r[r_r][c];
        end
      end
      ST_JM, ST_JE: begin
        for (int c = 0; c < 3; c++) begin
          lane_a[c] = 33'(cg_r[c]);
          lane_b[c] = d_r[g_r];
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar c = 0; c < 3; c++) begin : g_lane
    wvrj_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk  (clk),
      .op_a (lane_a[c]),
      .op_b (lane_b[c]),
      .q    (lane_q[c])
    );
  end

  assign mrg_base = (st_r == ST_NS) ? pos_row : gtr_r[r_r];
  assign mrg_offs = (st_r == ST_NS) ? vd_r : '0;

  wvrj_merge u_merge (
    .base (mrg_base),
    .offs (mrg_offs),
    .p0   (lane_q[0]),
    .p1   (lane_q[1]),
    .p2   (lane_q[2]),
    .sum  (mrg_sum)
  );

  always_ff @(posedge clk) begin
    case (st_r)
      ST_ND, ST_JC: begin
        for (int c = 0; c < 3; c++) begin
          d_r[c] <= wvrj_pkg::sat_sub(prev_r[c], pos_rd[c]);
        end
      end
      ST_NS: s_r <= mrg_sum;
      ST_RS: diff_r <= wvrj_pkg::sat_sub(mrg_sum, tgt_r[r_r]);
      ST_RW: res_r[r_r] <= lane_q[0];
      ST_JK: coeff_r <= lane_q[0];
      ST_JH: begin
        for (int c = 0; c < 3; c++) begin
          cg_r[c] <= lane_q[c];
        end
      end
      default: begin
      end
    endcase
    if (in_fire && in_if.opcode == wvrj_pkg::OP_NROW) begin
      row_r <= in_if.row;
      lastn_r <= in_if.last_node;
      va_r[0] <= in_if.val_a;
      va_r[1] <= in_if.val_b;
      va_r[2] <= in_if.val_c;
      vd_r <= in_if.val_d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      cw_r <= 31'd65536;
      jen_r <= 1'b1;
      for (int i = 0; i < 3; i++) begin
        for (int c = 0; c < 3; c++) begin
          grot_r[i][c] <= '0;
        end
        gtr_r[i] <= '0;
        prev_r[i] <= '0;
        tgt_r[i] <= '0;
        acc_r[i] <= '0;
      end
      node_count_r <= '0;
      ovf_r <= 1'b0;
      cur_stored_r <= 1'b0;
      cur_slot_r <= '0;
      r_r <= '0;
      g_r <= '0;
      j_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          wvrj_pkg::CFG_COST_WEIGHT: cw_r <= cfg_data;
          default:                   jen_r <= cfg_data[0];
        endcase
      end
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        ST_IDLE: begin
          if (in_fire) begin
            case (in_if.opcode)
              wvrj_pkg::OP_GROW: begin
                if (in_if.row != 2'd3) begin
                  grot_r[in_if.row][0] <= in_if.val_a;
                  grot_r[in_if.row][1] <= in_if.val_b;
                  grot_r[in_if.row][2] <= in_if.val_c;
                  gtr_r[in_if.row] <= in_if.val_d;
                end
              end
              wvrj_pkg::OP_PREV: begin
                prev_r[0] <= in_if.val_a;
                prev_r[1] <= in_if.val_b;
                prev_r[2] <= in_if.val_c;
              end
              wvrj_pkg::OP_TGT: begin
                tgt_r[0] <= in_if.val_a;
                tgt_r[1] <= in_if.val_b;
                tgt_r[2] <= in_if.val_c;
              end
              wvrj_pkg::OP_HDR: begin
                if (node_count_r < CW'(MAX_NODES)) begin
                  cur_slot_r <= node_count_r[JW-1:0];
                  node_count_r <= node_count_r + CW'(1);
                  cur_stored_r <= 1'b1;
                end else begin
                  ovf_r <= 1'b1;
                  cur_stored_r <= 1'b0;
                end
              end
              wvrj_pkg::OP_NROW: begin
                if (in_if.row != 2'd3) begin
                  if (cur_stored_r) begin
                    st_r <= ST_NA;
                  end else if (in_if.row == 2'd2 && in_if.last_node) begin
                    r_r <= 2'd0;
                    st_r <= ST_RP;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_NA: st_r <= ST_ND;
        ST_ND: st_r <= ST_NP;
        ST_NP: st_r <= ST_NS;
        ST_NS: st_r <= ST_NM;
        ST_NM: st_r <= ST_NW;
        ST_NW: begin
          acc_r[row_r] <= wvrj_pkg::sat32(36'(acc_r[row_r]) + 36'(lane_q[0]));
          if (row_r == 2'd2 && lastn_r) begin
            r_r <= 2'd0;
            st_r <= ST_RP;
          end else begin
            st_r <= ST_IDLE;
          end
        end
        ST_RP: st_r <= ST_RS;
        ST_RS: st_r <= ST_RM;
        ST_RM: st_r <= ST_RW;
        ST_RW: begin
          if (r_r == 2'd2) begin
            st_r <= ST_REMIT;
          end else begin
            r_r <= r_r + 2'd1;
            st_r <= ST_RP;
          end
        end
        ST_REMIT: begin
          if (emit_ok) begin
            out_kind_r <= wvrj_pkg::KIND_RES;
            out_node_r <= '0;
            out_rrow_r <= '0;
            out_group_r <= '0;
            out_x_r <= res_r[0];
            out_y_r <= res_r[1];
            out_z_r <= res_r[2];
            out_ovf_r <= ovf_r;
            if (jen_r && node_count_r != '0) begin
              out_last_r <= 1'b0;
              j_r <= '0;
              st_r <= ST_JA;
            end else begin
              out_last_r <= 1'b1;
              for (int c = 0; c < 3; c++) begin
                acc_r[c] <= '0;
              end
              node_count_r <= '0;
              ovf_r <= 1'b0;
              cur_stored_r <= 1'b0;
              cur_slot_r <= '0;
              st_r <= ST_IDLE;
            end
          end
        end
        ST_JA: st_r <= ST_JC;
        ST_JC: st_r <= ST_JK;
        ST_JK: begin
          r_r <= 2'd0;
          st_r <= ST_JG;
        end
        ST_JG: st_r <= ST_JH;
        ST_JH: begin
          g_r <= 2'd0;
          st_r <= ST_JM;
        end
        ST_JM: st_r <= ST_JE;
        ST_JE: begin
          if (emit_ok) begin
            out_kind_r <= wvrj_pkg::KIND_JAC;
            out_node_r <= 2'(j_r);
            out_rrow_r <= r_r;
            out_group_r <= g_r;
            out_x_r <= lane_q[0];
            out_y_r <= lane_q[1];
            out_z_r <= lane_q[2];
            out_ovf_r <= ovf_r;
            out_last_r <= 1'b0;
            if (g_r == 2'd2) begin
              st_r <= ST_JT;
            end else begin
              g_r <= g_r + 2'd1;
              st_r <= ST_JM;
            end
          end
        end
        ST_JT: begin
          if (emit_ok) begin
            out_kind_r <= wvrj_pkg::KIND_JAC;
            out_node_r <= 2'(j_r);
            out_rrow_r <= r_r;
            out_group_r <= wvrj_pkg::GRP_TRANS;
            out_x_r <= cg_r[0];
            out_y_r <= cg_r[1];
            out_z_r <= cg_r[2];
            out_ovf_r <= ovf_r;
            out_last_r <= jac_last;
            if (r_r != 2'd2) begin
              r_r <= r_r + 2'd1;
              st_r <= ST_JG;
            end else if (!jac_last) begin
              j_r <= j_r + JW'(1);
              st_r <= ST_JA;
            end else begin
              for (int c = 0; c < 3; c++) begin
                acc_r[c] <= '0;
              end
              node_count_r <= '0;
              ovf_r <= 1'b0;
              cur_stored_r <= 1'b0;
              cur_slot_r <= '0;
              st_r <= ST_IDLE;
            end
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.kind = out_kind_r;
  assign out_if.node_index = out_node_r;
  assign out_if.residual_row = out_rrow_r;
  assign out_if.group = out_group_r;
  assign out_if.out_x = out_x_r;
  assign out_if.out_y = out_y_r;
  assign out_if.out_z = out_z_r;
  assign out_if.node_overflow = out_ovf_r;
  assign out_if.last = out_last_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    node_count_r <= CW'(MAX_NODES))
    else $error("node count beyond limit");
  a_slot_stored: assert property (@(posedge clk) disable iff (!rst_n)
    cur_stored_r |-> (CW'(cur_slot_r) < node_count_r))
    else $error("current slot not among stored nodes");
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_JT && emit_ok && jac_last) |=> (node_count_r == '0 && !ovf_r))
    else $error("vertex state not cleared after last word");
  a_jac_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_JA) |-> (jen_r && node_count_r != '0))
    else $error("jacobian walk without nodes or enable");
`endif
endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the warped vertex residual and Jacobian block.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [1:0]         row;
    logic signed [31:0] val_a;
    logic signed [31:0] val_b;
    logic signed [31:0] val_c;
    logic signed [31:0] val_d;
    logic               last_node;
  } item_t;

  typedef struct packed {
    logic               kind;
    logic [1:0]         node_index;
    logic [1:0]         residual_row;
    logic [1:0]         group;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               node_overflow;
    logic               last;
  } word_t;

  localparam int NODE_LIMIT = 4;
  localparam int FRAC = 16;
  localparam int CYCLE_LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [30:0] cfg_data = '0;

  wvrj_in_if in_ch();
  wvrj_out_if out_ch();

  warped_vertex_residual_jacobian u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_if(in_ch.sink), .out_if(out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  item_t pending_items[$];
  word_t expected_words[$];
  int errors = 0;
  int words_seen = 0;
  int items_sent = 0;
  int vertices_done = 0;
  longint cycles = 0;
  bit hold_sender = 1'b0;

  // shadow of block state
  wvrj_pkg::q_t g_rot[9];
  wvrj_pkg::q_t g_trans[3];
  wvrj_pkg::q_t prev_v[3];
  wvrj_pkg::q_t tgt_v[3];
  wvrj_pkg::q_t node_pos[12];
  wvrj_pkg::q_t node_w[4];
  wvrj_pkg::q_t warp[3];
  int node_cnt;
  bit ovf;
  bit cur_stored;
  int cur_slot;
  logic [30:0] cost_w;
  bit jac_en;

  function automatic wvrj_pkg::q_t sat(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic wvrj_pkg::q_t qmul(input logic signed [63:0] a,
                                        input logic signed [63:0] b);
    logic signed [63:0] p;
    p = a * b + (64'sd1 <<< (FRAC - 1));
    return sat(p >>> FRAC);
  endfunction

  function automatic wvrj_pkg::q_t diff(input wvrj_pkg::q_t a, input wvrj_pkg::q_t b);
    return sat(64'(a) - 64'(b));
  endfunction

  function automatic void clear_vertex();
    warp = '{default: 0};
    node_cnt = 0;
    ovf = 0;
    cur_stored = 0;
    cur_slot = 0;
  endfunction

  function automatic void add_item(input item_t it);
    pending_items = {pending_items, it};
  endfunction

  function automatic void push_word(input logic kind, input int node, input int r,
                                    input int g, input wvrj_pkg::q_t x,
                                    input wvrj_pkg::q_t y, input wvrj_pkg::q_t z);
    word_t w;
    w.kind = kind;
    w.node_index = node[1:0];
    w.residual_row = r[1:0];
    w.group = g[1:0];
    w.out_x = x;
    w.out_y = y;
    w.out_z = z;
    w.node_overflow = ovf;
    w.last = 1'b0;
    expected_words = {expected_words, w};
  endfunction

  function automatic void emit_vertex();
    wvrj_pkg::q_t res[3];
    wvrj_pkg::q_t d[3];
    wvrj_pkg::q_t v[3];
    wvrj_pkg::q_t coeff;
    wvrj_pkg::q_t cg;
    logic signed [63:0] s;
    word_t w;
    for (int r = 0; r < 3; r++) begin
      s = 64'(g_trans[r]);
      for (int c = 0; c < 3; c++) s += 64'(qmul(g_rot[3*r+c], warp[c]));
      res[r] = qmul({33'd0, cost_w}, diff(sat(s), tgt_v[r]));
    end
    push_word(wvrj_pkg::KIND_RES, 0, 0, 0, res[0], res[1], res[2]);
    if (jac_en) begin
      for (int j = 0; j < node_cnt; j++) begin
        coeff = qmul({33'd0, cost_w}, node_w[j]);
        for (int c = 0; c < 3; c++) d[c] = diff(prev_v[c], node_pos[3*j+c]);
        for (int r = 0; r < 3; r++) begin
          for (int g = 0; g < 4; g++) begin
            for (int c = 0; c < 3; c++) begin
              cg = qmul(coeff, g_rot[3*r+c]);
              v[c] = (g < 3) ? qmul(cg, d[g]) : cg;
            end
            push_word(wvrj_pkg::KIND_JAC, j, r, g, v[0], v[1], v[2]);
          end
        end
      end
    end
    w = expected_words.pop_back();
    w.last = 1'b1;
    expected_words = {expected_words, w};
    clear_vertex();
  endfunction

  function automatic void predict_item(input item_t it);
    logic signed [63:0] s;
    wvrj_pkg::q_t wt;
    case (it.opcode)
      wvrj_pkg::OP_GROW: begin
        if (it.row <= 2) begin
          g_rot[3*it.row] = it.val_a;
          g_rot[3*it.row+1] = it.val_b;
          g_rot[3*it.row+2] = it.val_c;
          g_trans[it.row] = it.val_d;
        end
      end
      wvrj_pkg::OP_PREV: prev_v = '{it.val_a, it.val_b, it.val_c};
      wvrj_pkg::OP_TGT: tgt_v = '{it.val_a, it.val_b, it.val_c};
      wvrj_pkg::OP_HDR: begin
        if (node_cnt < NODE_LIMIT) begin
          cur_slot = node_cnt;
          node_pos[3*cur_slot] = it.val_a;
          node_pos[3*cur_slot+1] = it.val_b;
          node_pos[3*cur_slot+2] = it.val_c;
          node_w[cur_slot] = it.val_d;
          node_cnt++;
          cur_stored = 1;
        end else begin
          ovf = 1;
          cur_stored = 0;
        end
      end
      wvrj_pkg::OP_NROW: begin
        if (it.row <= 2) begin
          if (cur_stored) begin
            s = 64'(node_pos[3*cur_slot+it.row]) + 64'(it.val_d);
            s += 64'(qmul(it.val_a, diff(prev_v[0], node_pos[3*cur_slot])));
            s += 64'(qmul(it.val_b, diff(prev_v[1], node_pos[3*cur_slot+1])));
            s += 64'(qmul(it.val_c, diff(prev_v[2], node_pos[3*cur_slot+2])));
            wt = qmul(node_w[cur_slot], sat(s));
            warp[it.row] = sat(64'(warp[it.row]) + 64'(wt));
          end
          if (it.row == 2 && it.last_node) emit_vertex();
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic wvrj_pkg::q_t rand_q();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom();
      3: return $urandom();
      default: return $signed($urandom_range(0, 262143)) - 32'sd131072;
    endcase
  endfunction

  function automatic item_t make_item(input logic [2:0] op, input logic [1:0] r,
                                      input wvrj_pkg::q_t a, input wvrj_pkg::q_t b,
                                      input wvrj_pkg::q_t c, input wvrj_pkg::q_t d,
                                      input logic ln);
    item_t it;
    it.opcode = op; it.row = r; it.val_a = a; it.val_b = b;
    it.val_c = c; it.val_d = d; it.last_node = ln;
    return it;
  endfunction

  // driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.opcode <= '0; in_ch.row <= '0; in_ch.last_node <= 1'b0;
      in_ch.val_a <= '0; in_ch.val_b <= '0; in_ch.val_c <= '0; in_ch.val_d <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_item(pending_items.pop_front());
        items_sent++;
        send_gap = gap_len();
      end
      if ((in_ch.valid && !in_ch.ready)) begin
        in_ch.valid <= 1'b1;
      end else if (send_gap > 0 || hold_sender || pending_items.size() == 0) begin
        if (send_gap > 0) send_gap--;
        in_ch.valid <= 1'b0;
      end else begin
        in_ch.valid <= 1'b1;
        {in_ch.opcode, in_ch.row, in_ch.val_a, in_ch.val_b, in_ch.val_c, in_ch.val_d,
         in_ch.last_node} <= pending_items[0];
      end
    end
  end

  // monitor
  int stall = 0;
  always @(posedge clk) begin
    word_t got;
    word_t exp_w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.kind, out_ch.node_index, out_ch.residual_row, out_ch.group,
               out_ch.out_x, out_ch.out_y, out_ch.out_z, out_ch.node_overflow, out_ch.last};
        words_seen++;
        if (expected_words.size() == 0) begin
          $error("unexpected result word %h", got);
          errors++;
        end else begin
          exp_w = expected_words.pop_front();
          if (got.last) vertices_done++;
          if (got.kind !== exp_w.kind) begin
            $error("kind exp %0d got %0d", exp_w.kind, got.kind); errors++;
          end
          if (got.node_index !== exp_w.node_index) begin
            $error("node_index exp %0d got %0d", exp_w.node_index, got.node_index);
            errors++;
          end
          if (got.residual_row !== exp_w.residual_row) begin
            $error("residual_row exp %0d got %0d", exp_w.residual_row, got.residual_row);
            errors++;
          end
          if (got.group !== exp_w.group) begin
            $error("group exp %0d got %0d", exp_w.group, got.group); errors++;
          end
          if (got.out_x !== exp_w.out_x) begin
            $error("out_x exp %0d got %0d", exp_w.out_x, got.out_x); errors++;
          end
          if (got.out_y !== exp_w.out_y) begin
            $error("out_y exp %0d got %0d", exp_w.out_y, got.out_y); errors++;
          end
          if (got.out_z !== exp_w.out_z) begin
            $error("out_z exp %0d got %0d", exp_w.out_z, got.out_z); errors++;
          end
          if (got.node_overflow !== exp_w.node_overflow) begin
            $error("node_overflow exp %0d got %0d", exp_w.node_overflow,
                   got.node_overflow);
            errors++;
          end
          if (got.last !== exp_w.last) begin
            $error("last exp %0d got %0d", exp_w.last, got.last); errors++;
          end
        end
      end
      if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_cfg(input logic idx, input logic [30:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == wvrj_pkg::CFG_COST_WEIGHT) cost_w = value;
    else jac_en = value[0];
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_ch.valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // one vertex with n node headers, with occasional stray items mixed in
  task automatic queue_vertex(input int n);
    if ($urandom_range(0, 3) == 0)
      for (int r = 0; r < 3; r++)
        add_item(make_item(wvrj_pkg::OP_GROW, 2'(r), rand_q(), rand_q(), rand_q(),
                           rand_q(), 1'($urandom_range(0, 1))));
    add_item(make_item(wvrj_pkg::OP_PREV, 2'($urandom_range(0, 3)), rand_q(), rand_q(),
                       rand_q(), rand_q(), 1'($urandom_range(0, 1))));
    add_item(make_item(wvrj_pkg::OP_TGT, 2'($urandom_range(0, 3)), rand_q(), rand_q(),
                       rand_q(), rand_q(), 1'($urandom_range(0, 1))));
    for (int j = 0; j < n; j++) begin
      add_item(make_item(wvrj_pkg::OP_HDR, 2'($urandom_range(0, 3)), rand_q(), rand_q(),
                         rand_q(), rand_q(), j == n - 1));
      for (int r = 0; r < 3; r++) begin
        if ($urandom_range(0, 15) == 0)
          add_item(make_item(3'($urandom_range(5, 7)), 2'($urandom_range(0, 3)),
                             rand_q(), rand_q(), rand_q(), rand_q(),
                             1'($urandom_range(0, 1))));
        if ($urandom_range(0, 15) == 0)
          add_item(make_item(wvrj_pkg::OP_NROW, 2'd3, rand_q(), rand_q(), rand_q(),
                             rand_q(), 1'b1));
        add_item(make_item(wvrj_pkg::OP_NROW, 2'(r), rand_q(), rand_q(), rand_q(),
                           rand_q(), (j == n - 1) && (r == 2)));
      end
    end
    if (n == 0)
      add_item(make_item(wvrj_pkg::OP_NROW, 2'd2, rand_q(), rand_q(), rand_q(),
                         rand_q(), 1'b1));
  endtask

  initial begin
    g_rot = '{default: 0}; g_trans = '{default: 0};
    prev_v = '{default: 0}; tgt_v = '{default: 0};
    node_pos = '{default: 0}; node_w = '{default: 0};
    clear_vertex();
    cost_w = 31'd65536;
    jac_en = 1'b1;
    out_ch.ready = 1'b0;
    in_ch.valid = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: identity transform, extremes, no nodes, overflow, orphan rows
    write_cfg(wvrj_pkg::CFG_COST_WEIGHT, 31'd65536);
    write_cfg(wvrj_pkg::CFG_JAC_EN, 31'd1);
    add_item(make_item(wvrj_pkg::OP_NROW, 2'd2, 32'sd65536, 0, 0, 32'sd7, 1'b1));
    add_item(make_item(wvrj_pkg::OP_GROW, 2'd0, 32'sd65536, 0, 0, 32'sd100, 1'b0));
    add_item(make_item(wvrj_pkg::OP_GROW, 2'd1, 0, 32'sd65536, 0, 32'sh80000000, 1'b0));
    add_item(make_item(wvrj_pkg::OP_GROW, 2'd2, 32'sh7fffffff, 32'sh80000000,
                       32'sd65536, 32'sh7fffffff, 1'b1));
    add_item(make_item(wvrj_pkg::OP_GROW, 2'd3, 1, 2, 3, 4, 1'b1));
    add_item(make_item(3'd5, 2'd0, 1, 2, 3, 4, 1'b1));
    add_item(make_item(3'd7, 2'd3, -1, -1, -1, -1, 1'b1));
    add_item(make_item(wvrj_pkg::OP_PREV, 2'd0, 32'sh7fffffff, 32'sh80000000, 0, -1,
                       1'b0));
    add_item(make_item(wvrj_pkg::OP_TGT, 2'd0, 32'sh80000000, 32'sh7fffffff, -1, 0,
                       1'b0));
    add_item(make_item(wvrj_pkg::OP_NROW, 2'd2, 0, 0, 0, 0, 1'b1));
    for (int j = 0; j < 5; j++) begin
      add_item(make_item(wvrj_pkg::OP_HDR, 2'd0, 32'sh80000000, 32'sh7fffffff,
                         32'sd65536 * j, 32'sh7fffffff, j == 4));
      add_item(make_item(wvrj_pkg::OP_NROW, 2'd0, 32'sh7fffffff, 32'sh80000000, -1,
                         32'sh7fffffff, 1'b0));
      add_item(make_item(wvrj_pkg::OP_NROW, 2'd0, 32'sd65536, 0, 0, 0, 1'b0));
      add_item(make_item(wvrj_pkg::OP_NROW, 2'd2, 0, 0, 32'sh80000000, -1, j == 4));
    end
    drain();

    write_cfg(wvrj_pkg::CFG_COST_WEIGHT, 31'h7fffffff);
    write_cfg(wvrj_pkg::CFG_JAC_EN, 31'd0);
    queue_vertex(2);
    queue_vertex(0);
    drain();
    write_cfg(wvrj_pkg::CFG_COST_WEIGHT, 31'd0);
    write_cfg(wvrj_pkg::CFG_JAC_EN, 31'd1);
    queue_vertex(4);
    drain();

    // random phases
    for (int ph = 0; ph < 6; ph++) begin
      write_cfg(wvrj_pkg::CFG_COST_WEIGHT,
                (ph % 3 == 0) ? 31'd65536 : 31'($urandom()));
      write_cfg(wvrj_pkg::CFG_JAC_EN, 31'(ph != 4));
      for (int v = 0; v < 5; v++) begin
        if ($urandom_range(0, 9) == 0) begin
          for (int k = 0; k < 4; k++)
            add_item(make_item(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                               rand_q(), rand_q(), rand_q(), rand_q(),
                               1'($urandom_range(0, 1))));
          add_item(make_item(wvrj_pkg::OP_NROW, 2'd2, rand_q(), rand_q(), rand_q(),
                             rand_q(), 1'b1));
        end else begin
          queue_vertex($urandom_range(0, 9) == 0 ? 5 : $urandom_range(0, 4));
        end
      end
      if (ph == 2) begin
        while (pending_items.size() > 20) @(posedge clk);
        hold_sender = 1'b1;
        while (expected_words.size() != 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      drain();
    end

    $display("sent %0d items, checked %0d result words over %0d vertices",
             items_sent, words_seen, vertices_done);
    $display("covered overflow, empty vertices, orphan rows and config extremes");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ filelist.f @@
sv/wvrj_pkg.sv
sv/wvrj_if.sv
sv/wvrj_ram.sv
sv/wvrj_lane.sv
sv/wvrj_merge.sv
sv/warped_vertex_residual_jacobian.sv
tb/testbench.sv
